// ===== rtl/core/dadc_pkg.sv =====
// Package for the dual absolute dial counter.
// Holds the request op codes, register indexes, nibble masks and the result record.
// Used by dadc_dial, dadc_core and dual_absolute_dial_counter_top.
package dadc_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLR_A  = 2'd1,
    OP_CLR_B  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic REG_DIAL_A_SWAPPED = 1'b0;
  localparam logic REG_DIAL_B_SWAPPED = 1'b1;

  localparam logic [3:0] SWAP_HI_MASK = 4'b1010;
  localparam logic [3:0] SWAP_LO_MASK = 4'b0101;
  localparam logic [7:0] LOW_NIBBLE   = 8'h0F;
  localparam logic [7:0] HIGH_NIBBLE  = 8'hF0;

  // A position difference of this size is a wrap across 0/15.
  localparam logic [4:0] WRAP_UP   = 5'd15;
  localparam logic [4:0] WRAP_DOWN = 5'd17;  // -15 in five bits

  localparam logic [1:0] GROUP_LAST = 2'd2;

  typedef struct packed {
    logic               group_done;
    logic [3:0]         dial_a_value;
    logic [3:0]         dial_b_value;
    logic signed [15:0] dial_a_count;
    logic signed [15:0] dial_b_count;
  } result_t;

endpackage

// ===== rtl/core/dual_absolute_dial_counter_top.sv =====
// Top level of the dual absolute dial counter.
// Input register, dadc_core state logic and output register; depends on dadc_pkg.
//
// Usage: each input request carries an op and a raw 8-bit sample word (low
// nibble dial A, high nibble dial B). A sample op stores the word in the
// current group of three; the third sample completes the group, the majority
// word sets both dial positions and each count moves by at most one step.
// Clear ops zero one count. Every request gives exactly one result request
// with group_done, both positions and both signed 16-bit counts.
// A request is held in the input register once it is accepted; its result
// is loaded into the result register when the request advances. Throughput:
// one request per cycle while the receiver does not stall, as dadc_core
// updates its state each time a request advances.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more; then in_stall_o rises.
// Reset clears the group, positions, counts and both swap registers. The user
// must make configuration writes via cfg_we_i only while idle; it is unchecked.
module dual_absolute_dial_counter_top
  import dadc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         raw_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               group_done_o,
  output logic [3:0]         dial_a_value_o,
  output logic [3:0]         dial_b_value_o,
  output logic signed [15:0] dial_a_count_o,
  output logic signed [15:0] dial_b_count_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic               cfg_wdata_i
);

  logic       a_swap_q, b_swap_q;
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_raw_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       out_ready, adv, in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_swap_q <= 1'b0;
      b_swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIAL_A_SWAPPED: a_swap_q <= cfg_wdata_i;
        REG_DIAL_B_SWAPPED: b_swap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q  <= op_e'(op_i);
      s1_raw_q <= raw_byte_i;
    end
  end

  dadc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .op_i       (s1_op_q),
    .raw_byte_i (s1_raw_q),
    .a_swap_i   (a_swap_q),
    .b_swap_i   (b_swap_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign group_done_o   = out_q.group_done;
  assign dial_a_value_o = out_q.dial_a_value;
  assign dial_b_value_o = out_q.dial_b_value;
  assign dial_a_count_o = out_q.dial_a_count;
  assign dial_b_count_o = out_q.dial_b_count;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced request did not reach the result register");

  a_clear_b_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_op_q == OP_CLR_B |=> dial_b_count_o == 16'sd0 && !group_done_o)
    else $error("dial B clear result is wrong");

endmodule

// ===== rtl/core/dadc_dial.sv =====
// Step logic for one dial: bit pair swap, position difference and count update.
// Purely combinational; depends on dadc_pkg.
module dadc_dial
  import dadc_pkg::*;
(
  input  logic [3:0]         nibble_i,
  input  logic               swap_i,
  input  logic [3:0]         prev_i,
  input  logic signed [15:0] count_i,
  output logic [3:0]         value_o,
  output logic [3:0]         prev_o,
  output logic signed [15:0] count_o
);

  logic [4:0] diff;
  logic       step_up;

  always_comb begin
    if (swap_i) begin
      value_o = ((nibble_i & SWAP_LO_MASK) << 1) | ((nibble_i & SWAP_HI_MASK) >> 1);
    end else begin
      value_o = nibble_i;
    end
  end

  assign diff = {1'b0, value_o} - {1'b0, prev_i};

  always_comb begin
    // A jump of fifteen is a wrap, so it counts against its sign.
    if (diff == WRAP_UP) begin
      step_up = 1'b0;
    end else if (diff == WRAP_DOWN) begin
      step_up = 1'b1;
    end else begin
      step_up = ~diff[4];
    end
  end

  always_comb begin
    if (diff == 5'd0) begin
      prev_o  = prev_i;
      count_o = count_i;
    end else begin
      prev_o  = value_o;
      count_o = step_up ? count_i + 16'sd1 : count_i - 16'sd1;
    end
  end

endmodule

// ===== rtl/core/dadc_core.sv =====
// Dial state: sample group, majority pick, dial positions and step counts.
// Instantiates dadc_dial twice; depends on dadc_pkg.
module dadc_core
  import dadc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  op_e     op_i,
  input  logic [7:0] raw_byte_i,
  input  logic    a_swap_i,
  input  logic    b_swap_i,
  output result_t res_o
);

  logic [7:0]         samples_q [3];
  logic [1:0]         idx_q, idx_d;
  logic [3:0]         val_a_q, val_a_d, val_b_q, val_b_d;
  logic [3:0]         prev_a_q, prev_a_d, prev_b_q, prev_b_d;
  logic signed [15:0] steps_a_q, steps_a_d, steps_b_q, steps_b_d;

  logic [1:0]         slot;
  logic [7:0]         s0, s1, s2, pick;
  logic               complete;
  logic [3:0]         a_val, b_val, a_prev, b_prev;
  logic signed [15:0] a_cnt, b_cnt;

  assign slot = (idx_q > GROUP_LAST) ? GROUP_LAST : idx_q;
  assign complete = (op_i == OP_SAMPLE) && (slot == GROUP_LAST);

  // The group as it stands once this sample is written.
  assign s0 = samples_q[0];
  assign s1 = samples_q[1];
  assign s2 = (slot == GROUP_LAST) ? raw_byte_i : samples_q[2];

  // Majority of three; when all differ the oldest sample wins.
  assign pick = (s1 == s2 && s0 != s1) ? s1 : s0;

  dadc_dial u_dial_a (
    .nibble_i (pick[3:0]),
    .swap_i   (a_swap_i),
    .prev_i   (prev_a_q),
    .count_i  (steps_a_q),
    .value_o  (a_val),
    .prev_o   (a_prev),
    .count_o  (a_cnt)
  );

  dadc_dial u_dial_b (
    .nibble_i (4'((pick & HIGH_NIBBLE) >> 4)),
    .swap_i   (b_swap_i),
    .prev_i   (prev_b_q),
    .count_i  (steps_b_q),
    .value_o  (b_val),
    .prev_o   (b_prev),
    .count_o  (b_cnt)
  );

  always_comb begin
    idx_d     = idx_q;
    val_a_d   = val_a_q;
    val_b_d   = val_b_q;
    prev_a_d  = prev_a_q;
    prev_b_d  = prev_b_q;
    steps_a_d = steps_a_q;
    steps_b_d = steps_b_q;
    unique case (op_i)
      OP_SAMPLE: begin
        if (complete) begin
          idx_d     = 2'd0;
          val_a_d   = a_val;
          val_b_d   = b_val;
          prev_a_d  = a_prev;
          prev_b_d  = b_prev;
          steps_a_d = a_cnt;
          steps_b_d = b_cnt;
        end else begin
          idx_d = slot + 2'd1;
        end
      end
      OP_CLR_A: steps_a_d = '0;
      OP_CLR_B: steps_b_d = '0;
      default: ;
    endcase
  end

  assign res_o.group_done   = complete;
  assign res_o.dial_a_value = val_a_d;
  assign res_o.dial_b_value = val_b_d;
  assign res_o.dial_a_count = steps_a_d;
  assign res_o.dial_b_count = steps_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q[0] <= '0;
      samples_q[1] <= '0;
      samples_q[2] <= '0;
      idx_q        <= '0;
      val_a_q      <= '0;
      val_b_q      <= '0;
      prev_a_q     <= '0;
      prev_b_q     <= '0;
      steps_a_q    <= '0;
      steps_b_q    <= '0;
    end else if (adv_i) begin
      if (op_i == OP_SAMPLE) begin
        samples_q[slot] <= raw_byte_i;
      end
      idx_q     <= idx_d;
      val_a_q   <= val_a_d;
      val_b_q   <= val_b_d;
      prev_a_q  <= prev_a_d;
      prev_b_q  <= prev_b_d;
      steps_a_q <= steps_a_d;
      steps_b_q <= steps_b_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("group index left its range");

  a_done_restarts_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && complete |=> idx_q == 2'd0)
    else $error("completed group did not restart the index");

  a_clear_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && op_i == OP_CLR_A |=> steps_a_q == 16'sd0)
    else $error("dial A count not cleared");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(steps_a_q) && $stable(steps_b_q) && $stable(idx_q))
    else $error("dial state changed without a request");

endmodule

// ===== sim/tb_dual_absolute_dial_counter_top.sv =====
// Self-checking testbench for dual_absolute_dial_counter_top: directed table, then random requests.
// Results are checked against typed table rows or a cycle-free predictor of vote and step counts.
// Depends on dadc_pkg and the RTL of the top level only.
module tb_dual_absolute_dial_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dadc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i = OP_NONE;
  logic [7:0]         raw_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               group_done_o;
  logic [3:0]         dial_a_value_o;
  logic [3:0]         dial_b_value_o;
  logic signed [15:0] dial_a_count_o;
  logic signed [15:0] dial_b_count_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = REG_DIAL_A_SWAPPED;
  logic               cfg_wdata_i = 1'b0;

  dual_absolute_dial_counter_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .raw_byte_i     (raw_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .group_done_o   (group_done_o),
    .dial_a_value_o (dial_a_value_o),
    .dial_b_value_o (dial_b_value_o),
    .dial_a_count_o (dial_a_count_o),
    .dial_b_count_o (dial_b_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  typedef struct {
    op_e        op;
    logic [7:0] raw;
    bit         typed;
    result_t    want;
  } stim_row_t;

  stim_row_t stim_rows[$];
  result_t   pending_results[$];
  int        mismatch_count = 0;
  bit        quiet = 1'b0;

  // Predictor state.
  logic               swap_a_cfg = 1'b0;
  logic               swap_b_cfg = 1'b0;
  logic [7:0]         grp_words[3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0]         grp_idx = '0;
  logic [3:0]         pos_a = '0;
  logic [3:0]         pos_b = '0;
  logic [3:0]         last_a = '0;
  logic [3:0]         last_b = '0;
  logic signed [15:0] steps_a = '0;
  logic signed [15:0] steps_b = '0;

  function automatic logic [3:0] swap_pairs(logic [3:0] v);
    return {v[2], v[3], v[0], v[1]};
  endfunction

  function automatic void step_dial(input logic [3:0] now, inout logic [3:0] prev,
                                    inout logic signed [15:0] cnt);
    int diff;
    diff = int'(now) - int'(prev);
    if (diff == 0) return;
    // A jump between 0 and 15 is one step across the wrap point.
    if (diff == 15) diff = -1;
    else if (diff == -15) diff = 1;
    cnt = (diff > 0) ? cnt + 16'sd1 : cnt - 16'sd1;
    prev = now;
  endfunction

  function automatic result_t predict_dials(op_e op, logic [7:0] raw);
    result_t    r;
    logic [1:0] slot;
    logic [7:0] pick;
    r.group_done = 1'b0;
    case (op)
      OP_SAMPLE: begin
        slot = (grp_idx > GROUP_LAST) ? GROUP_LAST : grp_idx;
        grp_words[slot] = raw;
        if (slot == GROUP_LAST) begin
          grp_idx = '0;
          r.group_done = 1'b1;
          // Only the two newer words agreeing against the oldest overrides it.
          if (grp_words[1] == grp_words[2] && grp_words[0] != grp_words[1]) begin
            pick = grp_words[1];
          end else begin
            pick = grp_words[0];
          end
          pos_a = pick[3:0];
          pos_b = pick[7:4];
          if (swap_a_cfg) pos_a = swap_pairs(pos_a);
          if (swap_b_cfg) pos_b = swap_pairs(pos_b);
          step_dial(pos_a, last_a, steps_a);
          step_dial(pos_b, last_b, steps_b);
        end else begin
          grp_idx = slot + 2'd1;
        end
      end
      OP_CLR_A: steps_a = '0;
      OP_CLR_B: steps_b = '0;
      default: ;
    endcase
    r.dial_a_value = pos_a;
    r.dial_b_value = pos_b;
    r.dial_a_count = steps_a;
    r.dial_b_count = steps_b;
    return r;
  endfunction

  task automatic add_row(op_e op, logic [7:0] raw, bit typed, result_t want);
    stim_row_t row;
    row.op    = op;
    row.raw   = raw;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  task automatic send_request(op_e op, logic [7:0] raw, bit typed, result_t want);
    bit      taken;
    result_t predicted;
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    raw_byte_i <= raw;
    // Decide acceptance mid-cycle, where every signal has settled.
    do begin
      @(negedge clk_i);
      taken = in_valid_i && !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predicted = predict_dials(op, raw);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_swaps(logic swap_a, logic swap_b);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DIAL_A_SWAPPED;
    cfg_wdata_i <= swap_a;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DIAL_B_SWAPPED;
    cfg_wdata_i <= swap_b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    swap_a_cfg = swap_a;
    swap_b_cfg = swap_b;
  endtask

  function automatic logic [3:0] nibble_move();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 4'd1;
    if (r < 8) return 4'hF;
    if (r == 8) return 4'd0;
    return 4'($urandom);
  endfunction

  // Mostly slowly turning dials sampled in runs of equal words, with glitches,
  // clears, unused ops and plain noise mixed in.
  task automatic run_random(int n);
    op_e        op;
    logic [7:0] raw;
    logic [7:0] track;
    int         pick;
    int         i;
    track = 8'($urandom);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) op = OP_CLR_A;
      else if (pick < 8) op = OP_CLR_B;
      else if (pick < 11) op = OP_NONE;
      else op = OP_SAMPLE;
      raw = 8'($urandom);
      if (op == OP_SAMPLE && pick >= 25) begin
        if ($urandom_range(5) == 0) begin
          track = {track[7:4] + nibble_move(), track[3:0] + nibble_move()};
        end
        raw = track;
      end
      send_request(op, raw, 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(string what, result_t want, result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns %s: expected done=%0d a=%0h b=%0h cnt_a=%0d cnt_b=%0d,",
               $time, what, want.group_done, want.dial_a_value, want.dial_b_value,
               want.dial_a_count, want.dial_b_count);
      $display("  got done=%0d a=%0h b=%0h cnt_a=%0d cnt_b=%0d",
               seen.group_done, seen.dial_a_value, seen.dial_b_value,
               seen.dial_a_count, seen.dial_b_count);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 35);
  end

  // The result request is taken at the next rising edge; its payload is stable now.
  always @(negedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.group_done   = group_done_o;
      seen.dial_a_value = dial_a_value_o;
      seen.dial_b_value = dial_b_value_o;
      seen.dial_a_count = dial_a_count_o;
      seen.dial_b_count = dial_b_count_o;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.group_done !== want.group_done || seen.dial_a_value !== want.dial_a_value ||
            seen.dial_b_value !== want.dial_b_value ||
            seen.dial_a_count !== want.dial_a_count ||
            seen.dial_b_count !== want.dial_b_count) begin
          report_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int k;
    // Fresh state, then three full-scale words: 0 to 15 is one step down.
    add_row(OP_NONE,   8'h00, 1'b1, {1'b0, 4'h0, 4'h0, 16'sd0, 16'sd0});
    add_row(OP_SAMPLE, 8'hFF, 1'b1, {1'b0, 4'h0, 4'h0, 16'sd0, 16'sd0});
    add_row(OP_SAMPLE, 8'hFF, 1'b1, {1'b0, 4'h0, 4'h0, 16'sd0, 16'sd0});
    add_row(OP_SAMPLE, 8'hFF, 1'b1, {1'b1, 4'hF, 4'hF, -16'sd1, -16'sd1});
    add_row(OP_CLR_A,  8'h00, 1'b1, {1'b0, 4'hF, 4'hF, 16'sd0, -16'sd1});
    add_row(OP_CLR_B,  8'hFF, 1'b1, {1'b0, 4'hF, 4'hF, 16'sd0, 16'sd0});
    // 15 back to 0 is one step up.
    add_row(OP_SAMPLE, 8'h00, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h00, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h00, 1'b1, {1'b1, 4'h0, 4'h0, 16'sd1, 16'sd1});
    // All three words differ: the oldest one wins.
    add_row(OP_SAMPLE, 8'h12, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h34, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h56, 1'b0, '0);
    // The two newer words outvote the oldest; an unused op in between is ignored.
    add_row(OP_SAMPLE, 8'h00, 1'b0, '0);
    add_row(OP_NONE,   8'hFF, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h77, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h77, 1'b0, '0);
    // Oldest and newest agree.
    add_row(OP_SAMPLE, 8'hA5, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h3C, 1'b0, '0);
    add_row(OP_SAMPLE, 8'hA5, 1'b0, '0);
    // Two oldest agree, with a clear between samples.
    add_row(OP_SAMPLE, 8'h3C, 1'b0, '0);
    add_row(OP_CLR_A,  8'hFF, 1'b0, '0);
    add_row(OP_SAMPLE, 8'h3C, 1'b0, '0);
    add_row(OP_SAMPLE, 8'hC3, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_swaps(1'b0, 1'b0);
    for (k = 0; k < stim_rows.size(); k++) begin
      send_request(stim_rows[k].op, stim_rows[k].raw, stim_rows[k].typed, stim_rows[k].want);
    end

    write_swaps(1'b1, 1'b0);
    run_random(350);
    write_swaps(1'b0, 1'b1);
    quiet = 1'b1;
    run_random(250);
    quiet = 1'b0;
    run_random(100);
    write_swaps(1'b1, 1'b1);
    run_random(350);
    write_swaps(1'b0, 1'b0);
    run_random(300);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dadc_pkg.sv
rtl/core/dadc_dial.sv
rtl/core/dadc_core.sv
rtl/core/dual_absolute_dial_counter_top.sv
sim/tb_dual_absolute_dial_counter_top.sv
